### hw/rtl/pru_pkg.sv
// Shared types, codes and sizing constants for the page replacement unit.
// No dependencies; the front end, back end and top level refer to it by scoped names.
package pru_pkg;

	localparam int PAGE_BITS  = 19;
	localparam int MAX_FRAMES = 64;
	localparam int COUNT_BITS = 32;
	localparam int LFSR_BITS  = 16;

	localparam int FRAME_BITS = $clog2(MAX_FRAMES);
	localparam int NF_BITS    = $clog2(MAX_FRAMES + 1);
	localparam int PE_BITS    = FRAME_BITS + 2;
	localparam int NUM_PAGES  = 1 << PAGE_BITS;

	localparam logic [1:0] CMD_FETCH  = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_STORE  = 2'd2;
	localparam logic [1:0] CMD_MODIFY = 2'd3;

	localparam logic [1:0] POL_FIFO   = 2'd0;
	localparam logic [1:0] POL_CLOCK  = 2'd1;
	localparam logic [1:0] POL_RANDOM = 2'd2;

	localparam logic [1:0] REG_NUM_FRAMES = 2'd0;
	localparam logic [1:0] REG_POLICY     = 2'd1;
	localparam logic [1:0] REG_SEED       = 2'd2;

	localparam logic [1:0] EVICT_NONE  = 2'd0;
	localparam logic [1:0] EVICT_CLEAN = 2'd1;
	localparam logic [1:0] EVICT_DIRTY = 2'd2;

	// queued access: page and whether it marks the page dirty
	typedef struct packed {
		logic                 wr;
		logic [PAGE_BITS-1:0] page;
	} item_t;

	// configuration as seen by the back end
	typedef struct packed {
		logic [NF_BITS-1:0]   nf;
		logic [1:0]           policy;
		logic                 seed_load;
		logic [LFSR_BITS-1:0] seed;
	} ctl_t;

endpackage

### hw/rtl/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/pru_front.sv
// Front end: accepts accesses, classifies them, holds them in a two-entry queue.
// Depends on pru_pkg.
module pru_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [pru_pkg::PAGE_BITS-1:0] page_number,
	input  logic                          clearing,
	output logic                          q_valid,
	output pru_pkg::item_t                q_item,
	input  logic                          q_pop
);

	pru_pkg::item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       is_write;

	assign in_stall = clearing || (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];
	assign is_write = (cmd == pru_pkg::CMD_STORE) || (cmd == pru_pkg::CMD_MODIFY);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{wr: is_write, page: page_number};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	property p_no_pop_empty;
		@(posedge clk) disable iff (!arst_n) q_pop |-> (count_q != 2'd0);
	endproperty
	property p_no_push_clearing;
		@(posedge clk) disable iff (!arst_n) clearing |=> ($stable(count_q) || $fell(count_q[0]) || $fell(count_q[1]));
	endproperty
	property p_count_range;
		@(posedge clk) disable iff (!arst_n) count_q != 2'd3;
	endproperty

	a_no_pop_empty:     assert property (p_no_pop_empty)     else $error("pop from empty queue");
	a_no_push_clearing: assert property (p_no_push_clearing) else $error("push during clear");
	a_count_range:      assert property (p_count_range)      else $error("queue overflow");

endmodule

### hw/rtl/pru_back.sv
// Back end: page table lookup, fill, victim choice, eviction and result register.
// Depends on pru_pkg and pru_ram.
module pru_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pru_pkg::ctl_t                  ctl,
	input  logic                           q_valid,
	input  pru_pkg::item_t                 q_item,
	output logic                           q_pop,
	output logic                           clearing,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [1:0]                     evict_kind,
	output logic [pru_pkg::FRAME_BITS-1:0] frame_index,
	output logic [pru_pkg::PAGE_BITS-1:0]  victim_page,
	output logic [pru_pkg::COUNT_BITS-1:0] access_count,
	output logic [pru_pkg::COUNT_BITS-1:0] fault_count,
	output logic [pru_pkg::COUNT_BITS-1:0] disk_write_count
);

	localparam int FB = pru_pkg::FRAME_BITS;
	localparam int NB = pru_pkg::NF_BITS;
	localparam int PB = pru_pkg::PAGE_BITS;
	localparam int CB = pru_pkg::COUNT_BITS;
	localparam int LB = pru_pkg::LFSR_BITS;
	localparam int EB = pru_pkg::PE_BITS;
	localparam int BB = $clog2(LB);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOOK   = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_MOD    = 4'd3;
	localparam logic [3:0] ST_OWN_RD = 4'd4;
	localparam logic [3:0] ST_OWN    = 4'd5;
	localparam logic [3:0] ST_VPE    = 4'd6;
	localparam logic [3:0] ST_FILL   = 4'd7;

	logic [3:0]     state_q;
	pru_pkg::item_t item_q;
	logic [FB-1:0]  victim_q;
	logic [PB-1:0]  vpage_q;
	logic           dirty_q;
	logic [NB-1:0]  hand_q;
	logic [NB-1:0]  head_q;
	logic [NB-1:0]  filled_q;
	logic [LB-1:0]  lfsr_q;
	logic [NB-1:0]  rem_q;
	logic [BB-1:0]  bit_q;
	logic [pru_pkg::MAX_FRAMES-1:0] ref_q;
	logic [CB-1:0]  acc_q, flt_q, dsk_q;
	logic           clr_q;
	logic [PB-1:0]  clr_addr_q;
	logic           out_valid_q;

	// memory ports
	logic          pe_we, pe_re;
	logic [PB-1:0] pe_waddr, pe_raddr;
	logic [EB-1:0] pe_wdata, pe_rdata;
	logic          own_we, own_re;
	logic [FB-1:0] own_waddr, own_raddr;
	logic [PB-1:0] own_wdata, own_rdata;

	logic          out_free;
	logic          pe_valid, pe_dirty;
	logic [FB-1:0] pe_frame;
	logic          fill_ok;
	logic [NB-1:0] head_v, hand_v, scan_next, head_next;
	logic [LB-1:0] lfsr_step;
	logic          lfsr_fb;
	logic [NB:0]   rem_shift;
	logic [NB:0]   rem_sub;
	logic [NB-1:0] rem_next;
	logic          emit_look, emit_fill;

	assign out_free = !out_valid_q || !out_stall;
	assign pe_valid = pe_rdata[EB-1];
	assign pe_dirty = pe_rdata[EB-2];
	assign pe_frame = pe_rdata[FB-1:0];
	assign fill_ok  = (filled_q < ctl.nf);
	assign clearing = clr_q;
	assign q_pop    = (state_q == ST_IDLE) && !clr_q && q_valid;

	assign head_v    = (head_q >= ctl.nf) ? '0 : head_q;
	assign head_next = (head_v + NB'(1) == ctl.nf) ? '0 : head_v + NB'(1);
	assign hand_v    = hand_q;
	assign scan_next = (hand_v + NB'(1) == ctl.nf) ? '0 : hand_v + NB'(1);

	assign lfsr_fb   = lfsr_q[15] ^ lfsr_q[13] ^ lfsr_q[12] ^ lfsr_q[10];
	assign lfsr_step = ({lfsr_q[LB-2:0], lfsr_fb} == '0) ? LB'(1) : {lfsr_q[LB-2:0], lfsr_fb};

	// one bit of the restoring remainder per cycle
	assign rem_shift = {rem_q, lfsr_q[bit_q]};
	assign rem_sub   = rem_shift - {1'b0, ctl.nf};
	assign rem_next  = (rem_shift >= {1'b0, ctl.nf}) ? rem_sub[NB-1:0] : rem_shift[NB-1:0];

	assign emit_look = (state_q == ST_LOOK) && out_free && (pe_valid || fill_ok);
	assign emit_fill = (state_q == ST_FILL) && out_free;

	always_comb begin
		pe_we     = 1'b0;
		pe_waddr  = item_q.page;
		pe_wdata  = '0;
		pe_re     = 1'b0;
		pe_raddr  = item_q.page;
		own_we    = 1'b0;
		own_waddr = victim_q;
		own_wdata = item_q.page;
		own_re    = 1'b0;
		own_raddr = victim_q;
		unique case (state_q)
			ST_IDLE: begin
				if (clr_q) begin
					pe_we    = 1'b1;
					pe_waddr = clr_addr_q;
				end else if (q_valid) begin
					pe_re    = 1'b1;
					pe_raddr = q_item.page;
				end
			end
			ST_LOOK: begin
				if (emit_look) begin
					pe_we = 1'b1;
					if (pe_valid) begin
						pe_wdata = {1'b1, pe_dirty | item_q.wr, pe_frame};
					end else begin
						pe_wdata  = {1'b1, item_q.wr, filled_q[FB-1:0]};
						own_we    = 1'b1;
						own_waddr = filled_q[FB-1:0];
					end
				end
			end
			ST_OWN_RD: own_re = 1'b1;
			ST_OWN: begin
				pe_re    = 1'b1;
				pe_raddr = own_rdata;
			end
			ST_VPE: begin
				pe_we    = 1'b1;
				pe_waddr = vpage_q;
			end
			ST_FILL: begin
				if (emit_fill) begin
					pe_we    = 1'b1;
					pe_wdata = {1'b1, item_q.wr, victim_q};
					own_we   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	pru_ram #(.WIDTH(EB), .DEPTH(pru_pkg::NUM_PAGES)) u_page_ram (
		.clk(clk), .we(pe_we), .waddr(pe_waddr), .wdata(pe_wdata),
		.re(pe_re), .raddr(pe_raddr), .rdata(pe_rdata)
	);

	pru_ram #(.WIDTH(PB), .DEPTH(pru_pkg::MAX_FRAMES)) u_owner_ram (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.re(own_re), .raddr(own_raddr), .rdata(own_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_OWN) begin
			vpage_q <= own_rdata;
		end
		if (state_q == ST_VPE) begin
			dirty_q <= pe_dirty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			victim_q    <= '0;
			hand_q      <= '0;
			head_q      <= '0;
			filled_q    <= '0;
			lfsr_q      <= LB'(1);
			rem_q       <= '0;
			bit_q       <= '0;
			ref_q       <= '0;
			acc_q       <= '0;
			flt_q       <= '0;
			dsk_q       <= '0;
			out_valid_q <= 1'b0;
			hit         <= 1'b0;
			evict_kind  <= pru_pkg::EVICT_NONE;
			frame_index <= '0;
			victim_page <= '0;
		end else begin
			if (ctl.seed_load) begin
				lfsr_q <= (ctl.seed == '0) ? LB'(1) : ctl.seed;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (clr_q) begin
						clr_addr_q <= clr_addr_q + PB'(1);
						if (clr_addr_q == '1) begin
							clr_q <= 1'b0;
						end
					end else if (q_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (pe_valid || fill_ok) begin
						if (out_free) begin
							state_q <= ST_IDLE;
							if (pe_valid) begin
								ref_q[pe_frame] <= 1'b1;
							end else begin
								ref_q[filled_q[FB-1:0]] <= 1'b1;
								filled_q <= filled_q + NB'(1);
							end
						end
					end else if (ctl.policy == pru_pkg::POL_CLOCK) begin
						hand_q  <= (hand_q >= ctl.nf) ? '0 : hand_q;
						state_q <= ST_SCAN;
					end else if (ctl.policy == pru_pkg::POL_RANDOM) begin
						lfsr_q  <= lfsr_step;
						rem_q   <= '0;
						bit_q   <= BB'(LB - 1);
						state_q <= ST_MOD;
					end else begin
						victim_q <= head_v[FB-1:0];
						head_q   <= head_next;
						state_q  <= ST_OWN_RD;
					end
				end
				ST_SCAN: begin
					hand_q <= scan_next;
					if (ref_q[hand_v[FB-1:0]]) begin
						ref_q[hand_v[FB-1:0]] <= 1'b0;
					end else begin
						victim_q <= hand_v[FB-1:0];
						state_q  <= ST_OWN_RD;
					end
				end
				ST_MOD: begin
					rem_q <= rem_next;
					bit_q <= bit_q - BB'(1);
					if (bit_q == '0) begin
						victim_q <= rem_next[FB-1:0];
						state_q  <= ST_OWN_RD;
					end
				end
				ST_OWN_RD: state_q <= ST_OWN;
				ST_OWN:    state_q <= ST_VPE;
				ST_VPE:    state_q <= ST_FILL;
				ST_FILL: begin
					if (out_free) begin
						ref_q[victim_q] <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit_look || emit_fill) begin
				out_valid_q <= 1'b1;
				hit         <= emit_look && pe_valid;
				acc_q       <= (acc_q == '1) ? acc_q : acc_q + CB'(1);
				if (!(emit_look && pe_valid)) begin
					flt_q <= (flt_q == '1) ? flt_q : flt_q + CB'(1);
				end
				if (emit_fill && dirty_q) begin
					dsk_q <= (dsk_q == '1) ? dsk_q : dsk_q + CB'(1);
				end
				if (emit_fill) begin
					evict_kind  <= dirty_q ? pru_pkg::EVICT_DIRTY : pru_pkg::EVICT_CLEAN;
					frame_index <= victim_q;
					victim_page <= vpage_q;
				end else begin
					evict_kind  <= pru_pkg::EVICT_NONE;
					frame_index <= pe_valid ? pe_frame : filled_q[FB-1:0];
					victim_page <= '0;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign access_count     = acc_q;
	assign fault_count      = flt_q;
	assign disk_write_count = dsk_q;

	property p_fill_bound;
		@(posedge clk) disable iff (!arst_n) filled_q <= NB'(pru_pkg::MAX_FRAMES);
	endproperty
	property p_clear_idle;
		@(posedge clk) disable iff (!arst_n) clr_q |-> (state_q == ST_IDLE) && !out_valid_q;
	endproperty
	property p_result_source;
		@(posedge clk) disable iff (!arst_n)
			$rose(out_valid_q) |-> ($past(state_q) == ST_LOOK) || ($past(state_q) == ST_FILL);
	endproperty

	a_fill_bound:    assert property (p_fill_bound)    else $error("fill count overrun");
	a_clear_idle:    assert property (p_clear_idle)    else $error("work during clear");
	a_result_source: assert property (p_result_source) else $error("result from wrong state");

endmodule

### hw/rtl/page_replacement_unit.sv
// Page replacement unit, top level: configuration registers, front queue, back end.
// Depends on pru_pkg, pru_front, pru_back (and pru_ram through pru_back).
// Order: a hit or fill fault is answered at lookup; an eviction passes victim choice
//   (FIFO head, random pick or clock scan), owner read, victim page entry, then fill.
// Throughput: one item in flight in the back end; the page table port sets the pace.
// Reset: counters, pointers, reference bits cleared; the page table is then cleared by
//   a sweep over all 2^PAGE_BITS page entries (524288), during which no item is accepted.
module page_replacement_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [15:0]                    cfg_data,
	// access channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [pru_pkg::PAGE_BITS-1:0]  page_number,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [1:0]                     evict_kind,
	output logic [pru_pkg::FRAME_BITS-1:0] frame_index,
	output logic [pru_pkg::PAGE_BITS-1:0]  victim_page,
	output logic [pru_pkg::COUNT_BITS-1:0] access_count,
	output logic [pru_pkg::COUNT_BITS-1:0] fault_count,
	output logic [pru_pkg::COUNT_BITS-1:0] disk_write_count
);

	logic [6:0]     num_frames_q;
	logic [1:0]     policy_q;
	logic           seed_load;
	pru_pkg::ctl_t  ctl;
	logic           q_valid;
	pru_pkg::item_t q_item;
	logic           q_pop;
	logic           clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= 7'(pru_pkg::MAX_FRAMES);
			policy_q     <= pru_pkg::POL_FIFO;
		end else if (cfg_we) begin
			if (cfg_index == pru_pkg::REG_NUM_FRAMES) begin
				num_frames_q <= cfg_data[6:0];
			end else if (cfg_index == pru_pkg::REG_POLICY) begin
				policy_q <= cfg_data[1:0];
			end
		end
	end

	// the seed goes straight into the LFSR in the back end
	assign seed_load = cfg_we && (cfg_index == pru_pkg::REG_SEED);

	// frame count clamped to 1..MAX_FRAMES
	always_comb begin
		ctl.policy    = policy_q;
		ctl.seed_load = seed_load;
		ctl.seed      = cfg_data;
		priority if (num_frames_q == '0) begin
			ctl.nf = pru_pkg::NF_BITS'(1);
		end else if (num_frames_q > 7'(pru_pkg::MAX_FRAMES)) begin
			ctl.nf = pru_pkg::NF_BITS'(pru_pkg::MAX_FRAMES);
		end else begin
			ctl.nf = num_frames_q[pru_pkg::NF_BITS-1:0];
		end
	end

	pru_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .page_number(page_number),
		.clearing(clearing),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	pru_back u_back (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.clearing(clearing),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .evict_kind(evict_kind), .frame_index(frame_index),
		.victim_page(victim_page), .access_count(access_count),
		.fault_count(fault_count), .disk_write_count(disk_write_count)
	);

endmodule
